/* rtl/brfc_pkg.sv */
// ----------------------------------------------------------------------------
// brfc_pkg
// shared types, codes and sizes for the byte ring fifo with commit
// ----------------------------------------------------------------------------
`default_nettype none

package brfc_pkg;

  localparam int STORE_BYTES = 1024;
  localparam int PTR_W       = $clog2(STORE_BYTES);
  localparam int STAT_W      = 10;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [STAT_W-1:0] stat_t;

  typedef enum logic [2:0] {
    FUNC_STAGE_WR   = 3'd0,
    FUNC_COMMIT_WR  = 3'd1,
    FUNC_RESTART_WR = 3'd2,
    FUNC_STAGE_RD   = 3'd3,
    FUNC_COMMIT_RD  = 3'd4,
    FUNC_RESTART_RD = 3'd5,
    FUNC_NOP6       = 3'd6,
    FUNC_NOP7       = 3'd7
  } func_t;

  typedef struct packed {
    logic       we;
    ptr_t       waddr;
    logic [7:0] wdata;
    logic       re;
    ptr_t       raddr;
  } mem_req_t;

  typedef struct packed {
    logic  rd_hit;
    logic  accepted;
    stat_t used_bytes;
    stat_t free_bytes;
    logic  is_empty;
  } result_t;

  function automatic ptr_t ring_next(input ptr_t p);
    return (p == ptr_t'(STORE_BYTES - 1)) ? '0 : p + ptr_t'(1);
  endfunction

endpackage

`default_nettype wire

/* rtl/byte_ring_fifo_with_commit.sv */
// a result is registered and appears in the cycle after its input transaction
// throughput: one transaction per cycle while the result side keeps up
// the read byte comes from the store's registered read port, in step with the status
// reset: synchronous, clears all four pointers and the result valid flag
// the input is not ready while reset is high
// the byte store is not cleared; only committed entries are ever read
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_commit
// byte ring fifo with staged writes and reads, commit and restart
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_with_commit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // write_byte[7:0]
  input  wire logic [2:0]  s_tuser,   // func[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // read_byte[7:0], used_bytes[17:8],
                                      // free_bytes[27:18], is_empty[28]
  output logic [0:0]       m_tuser    // accepted[0]
);
  import brfc_pkg::*;

  logic       in_fire;
  mem_req_t   req;
  result_t    result;
  logic [7:0] rdata;
  logic [7:0] read_byte;

  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign in_fire  = s_tvalid && s_tready;

  brfc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .func       (func_t'(s_tuser)),
    .write_byte (s_tdata),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .result     (result),
    .req        (req)
  );

  brfc_ram #(
    .DEPTH (STORE_BYTES),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .re    (req.re),
    .raddr (req.raddr),
    .rdata (rdata)
  );

  assign read_byte  = result.rd_hit ? rdata : 8'd0;
  assign m_tdata    = {3'd0, result.is_empty, result.free_bytes,
                       result.used_bytes, read_byte};
  assign m_tuser[0] = result.accepted;

endmodule

`default_nettype wire

/* rtl/brfc_ram.sv */
// ----------------------------------------------------------------------------
// brfc_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module brfc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/brfc_ctrl.sv */
// ----------------------------------------------------------------------------
// brfc_ctrl
// pointer state, memory requests and the registered status result
// ----------------------------------------------------------------------------
`default_nettype none

module brfc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire brfc_pkg::func_t   func,
  input  wire logic [7:0]        write_byte,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output brfc_pkg::result_t      result,
  output brfc_pkg::mem_req_t     req
);
  import brfc_pkg::*;

  ptr_t rp, wp, srp, swp;
  ptr_t rp_next, wp_next, srp_next, swp_next;
  logic acc;
  logic [PTR_W:0] diff;
  ptr_t used, freeb;
  result_t result_next;

  always_comb begin
    rp_next  = rp;
    wp_next  = wp;
    srp_next = srp;
    swp_next = swp;
    acc      = 1'b0;
    req      = '0;
    req.waddr = swp;
    req.wdata = write_byte;
    req.raddr = srp;
    case (func)
      FUNC_STAGE_WR: begin
        if (ring_next(swp) != rp) begin
          acc      = 1'b1;
          req.we   = in_fire;
          swp_next = ring_next(swp);
        end
      end
      FUNC_COMMIT_WR:  wp_next  = swp;
      FUNC_RESTART_WR: swp_next = wp;
      FUNC_STAGE_RD: begin
        if (srp != wp) begin
          acc      = 1'b1;
          req.re   = in_fire;
          srp_next = ring_next(srp);
        end
      end
      FUNC_COMMIT_RD:  rp_next  = srp;
      FUNC_RESTART_RD: srp_next = rp;
      default: ;
    endcase

    if (wp_next >= rp_next) begin
      diff = {1'b0, wp_next} - {1'b0, rp_next};
    end else begin
      diff = {1'b0, wp_next} + (PTR_W+1)'(STORE_BYTES) - {1'b0, rp_next};
    end
    used  = diff[PTR_W-1:0];
    freeb = ptr_t'(STORE_BYTES - 1) - used;

    result_next.rd_hit     = acc && (func == FUNC_STAGE_RD);
    result_next.accepted   = acc;
    result_next.used_bytes = stat_t'(used);
    result_next.free_bytes = stat_t'(freeb);
    result_next.is_empty   = (rp_next == wp_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp  <= '0;
      wp  <= '0;
      srp <= '0;
      swp <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        rp  <= rp_next;
        wp  <= wp_next;
        srp <= srp_next;
        swp <= swp_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= result_next;
    end
  end

  a_no_wr_rd_same_cycle: assert property (@(posedge clk) disable iff (rst)
    !(req.we && req.re))
    else $error("memory read and write issued together");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("transaction did not produce a result");

  a_read_only_committed: assert property (@(posedge clk) disable iff (rst)
    req.re |-> (srp != wp))
    else $error("read past committed write pointer");

  a_write_keeps_gap: assert property (@(posedge clk) disable iff (rst)
    req.we |-> (ring_next(swp) != rp))
    else $error("write into the reserved empty slot");

endmodule

`default_nettype wire

/* tb/brfc_status_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brfc_status_checker
// watches both stream channels of the byte ring fifo, mirrors its pointers
// and store, and compares every result against the predicted fill status
// ----------------------------------------------------------------------------

module brfc_status_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // write_byte[7:0]
  input  wire logic [2:0]  s_tuser,   // func[2:0]
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,   // read_byte[7:0], used_bytes[17:8],
                                      // free_bytes[27:18], is_empty[28]
  input  wire logic [0:0]  m_tuser,   // accepted[0]
  output int               fail_count,
  output int               pending,
  output int               results_seen
);
  import brfc_pkg::*;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       accepted;
    stat_t      used_bytes;
    stat_t      free_bytes;
    logic       is_empty;
  } fifo_status_t;

  logic [7:0]   store_mirror [STORE_BYTES];
  ptr_t         rd_ptr, wr_ptr, stg_rd_ptr, stg_wr_ptr;
  fifo_status_t expected_status_q [$];
  int           n_fail = 0;
  int           n_results = 0;

  function automatic ptr_t ptr_step(input ptr_t p);
    return (int'(p) == STORE_BYTES - 1) ? '0 : ptr_t'(int'(p) + 1);
  endfunction

  function automatic fifo_status_t predict_status(input logic [2:0] f, input logic [7:0] b);
    fifo_status_t st;
    int           used;
    st = '0;
    case (func_t'(f))
      FUNC_STAGE_WR: begin
        if (ptr_step(stg_wr_ptr) != rd_ptr) begin
          store_mirror[stg_wr_ptr] = b;
          stg_wr_ptr = ptr_step(stg_wr_ptr);
          st.accepted = 1'b1;
        end
      end
      FUNC_COMMIT_WR:  wr_ptr = stg_wr_ptr;
      FUNC_RESTART_WR: stg_wr_ptr = wr_ptr;
      FUNC_STAGE_RD: begin
        if (stg_rd_ptr != wr_ptr) begin
          st.read_byte = store_mirror[stg_rd_ptr];
          stg_rd_ptr = ptr_step(stg_rd_ptr);
          st.accepted = 1'b1;
        end
      end
      FUNC_COMMIT_RD:  rd_ptr = stg_rd_ptr;
      FUNC_RESTART_RD: stg_rd_ptr = rd_ptr;
      default: ;
    endcase
    used = (int'(wr_ptr) - int'(rd_ptr) + STORE_BYTES) % STORE_BYTES;
    st.used_bytes = stat_t'(used);
    st.free_bytes = stat_t'(STORE_BYTES - 1 - used);
    st.is_empty   = (rd_ptr == wr_ptr);
    return st;
  endfunction

  always @(posedge clk) begin : monitor
    fifo_status_t exp_st;
    fifo_status_t got;
    if (rst) begin
      rd_ptr     = '0;
      wr_ptr     = '0;
      stg_rd_ptr = '0;
      stg_wr_ptr = '0;
      expected_status_q.delete();
    end else begin
      // results first: a result at this edge belongs to an earlier transaction
      if (m_tvalid && m_tready) begin
        n_results++;
        got.read_byte  = m_tdata[7:0];
        got.accepted   = m_tuser[0];
        got.used_bytes = m_tdata[17:8];
        got.free_bytes = m_tdata[27:18];
        got.is_empty   = m_tdata[28];
        if (expected_status_q.size() == 0) begin
          if (n_fail < 10)
            $display("%0t: result with no transaction pending: data=%08h user=%0b",
                     $time, m_tdata, m_tuser);
          n_fail++;
        end else begin
          exp_st = expected_status_q.pop_front();
          if (got.read_byte !== exp_st.read_byte || got.accepted !== exp_st.accepted ||
              got.used_bytes !== exp_st.used_bytes ||
              got.free_bytes !== exp_st.free_bytes || got.is_empty !== exp_st.is_empty) begin
            if (n_fail < 10) begin
              $display("%0t: mismatch expected byte=%02h acc=%0b used=%0d free=%0d empty=%0b",
                       $time, exp_st.read_byte, exp_st.accepted, exp_st.used_bytes,
                       exp_st.free_bytes, exp_st.is_empty);
              $display("%0t:          actual   byte=%02h acc=%0b used=%0d free=%0d empty=%0b",
                       $time, got.read_byte, got.accepted, got.used_bytes,
                       got.free_bytes, got.is_empty);
            end
            n_fail++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_status_q.push_back(predict_status(s_tuser, s_tdata));
    end
    fail_count   <= n_fail;
    pending      <= expected_status_q.size();
    results_seen <= n_results;
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the byte ring fifo with commit: directed cases,
// then random commit and restart sequences
// ----------------------------------------------------------------------------

module tb_top;
  import brfc_pkg::*;

  localparam int RANDOM_ITEMS    = 370;
  localparam int PRESSURE_CYCLES = 400;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;

  int fail_count;
  int pending;
  int results_seen;
  int items_sent  = 0;
  bit sender_fast = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  byte_ring_fifo_with_commit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  brfc_status_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_item(input func_t f, input logic [7:0] b);
    int gap;
    gap = sender_fast ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_burst(input int len);
    repeat (len) send_item(FUNC_STAGE_WR, 8'($urandom_range(0, 255)));
  endtask

  task automatic read_burst(input int len);
    repeat (len) send_item(FUNC_STAGE_RD, 8'($urandom_range(0, 255)));
  endtask

  initial begin : result_sink
    int  run;
    int  gap;
    bit  held;
    held = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && results_seen >= 150) begin
        // long hold so the result register stays full and stalls the block's input
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(negedge clk);
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
        m_tready <= 1'b1;
        repeat (run) @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    #(12 * 400000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int base;
    int sel;
    int len;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty fifo, unused codes, two-phase write and read, restarts
    send_item(FUNC_STAGE_RD, 8'hff);
    send_item(FUNC_COMMIT_RD, 8'h00);
    send_item(FUNC_RESTART_RD, 8'h00);
    send_item(FUNC_NOP6, 8'hff);
    send_item(FUNC_NOP7, 8'h00);
    send_item(FUNC_STAGE_WR, 8'h00);
    send_item(FUNC_STAGE_WR, 8'hff);
    send_item(FUNC_STAGE_WR, 8'ha5);
    send_item(FUNC_STAGE_WR, 8'h5a);
    send_item(FUNC_STAGE_RD, 8'h00);
    send_item(FUNC_COMMIT_WR, 8'hff);
    send_item(FUNC_STAGE_RD, 8'h00);
    send_item(FUNC_STAGE_RD, 8'h00);
    send_item(FUNC_RESTART_RD, 8'h00);
    send_item(FUNC_STAGE_RD, 8'h00);
    send_item(FUNC_COMMIT_RD, 8'h00);
    send_item(FUNC_STAGE_WR, 8'h3c);
    send_item(FUNC_RESTART_WR, 8'h00);
    send_item(FUNC_STAGE_WR, 8'h11);
    send_item(FUNC_COMMIT_WR, 8'h00);
    read_burst(5);
    send_item(FUNC_COMMIT_RD, 8'h00);

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 9);
      len = $urandom_range(1, 24);
      sender_fast = ($urandom_range(0, 6) == 0);
      if (sel < 4) begin
        write_burst(len);
        send_item(($urandom_range(0, 3) == 0) ? FUNC_RESTART_WR : FUNC_COMMIT_WR,
                  8'($urandom_range(0, 255)));
      end else if (sel < 8) begin
        read_burst(len);
        send_item(($urandom_range(0, 3) == 0) ? FUNC_RESTART_RD : FUNC_COMMIT_RD,
                  8'($urandom_range(0, 255)));
      end else begin
        send_item(func_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end
    end
    sender_fast = 1'b0;
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
